### hw/rtl/mctg_pkg.sv
// Shared types and fixed field widths for the MIDI clock tick generator.
// Depends on nothing; every other file of the block but mctg_checker imports it.

package mctg_pkg;

  // Field widths fixed by the channel format
  localparam int IDX_FIELD_W   = 5;
  localparam int VALUE_FIELD_W = 16;
  localparam int COUNT_FIELD_W = 16;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // One input item as held in the input register
  typedef struct packed {
    op_t                      op;
    logic [IDX_FIELD_W-1:0]   entry_index;
    logic [VALUE_FIELD_W-1:0] entry_value;
    logic                     stop_request;
    logic                     start_request;
    logic                     playing;
    logic                     tempo_raised;
  } item_t;

  // Timestamp table write command
  typedef struct packed {
    logic                     en;
    logic [IDX_FIELD_W-1:0]   idx;
    logic [VALUE_FIELD_W-1:0] value;
  } stamp_wr_t;

  // One result item
  typedef struct packed {
    logic                     clock_pulse;
    logic [IDX_FIELD_W-1:0]   pulse_index;
    logic [IDX_FIELD_W-1:0]   blink_phase;
    logic [COUNT_FIELD_W-1:0] tick_count;
  } result_t;

endpackage

### hw/rtl/mctg_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on mctg_pkg for the field widths.

interface mctg_in_if;
  import mctg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [IDX_FIELD_W-1:0]   entry_index;
  logic [VALUE_FIELD_W-1:0] entry_value;
  logic                     stop_request;
  logic                     start_request;
  logic                     playing;
  logic                     tempo_raised;

  modport source (
    output valid, op, entry_index, entry_value, stop_request, start_request,
           playing, tempo_raised,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, entry_value, stop_request, start_request,
           playing, tempo_raised,
    output ready
  );
  modport mon (
    input valid, ready, op, entry_index, entry_value, stop_request, start_request,
          playing, tempo_raised
  );
endinterface

interface mctg_out_if;
  import mctg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     clock_pulse;
  logic [IDX_FIELD_W-1:0]   pulse_index;
  logic [IDX_FIELD_W-1:0]   blink_phase;
  logic [COUNT_FIELD_W-1:0] tick_count;

  modport source (
    output valid, clock_pulse, pulse_index, blink_phase, tick_count,
    input  ready
  );
  modport sink (
    input  valid, clock_pulse, pulse_index, blink_phase, tick_count,
    output ready
  );
  modport mon (
    input valid, ready, clock_pulse, pulse_index, blink_phase, tick_count
  );
endinterface

### hw/rtl/midi_clock_tick_generator_top.sv
// MIDI clock tick generator, 24 pulses per quarter note: input register,
// tick core and timestamp table. Depends on mctg_pkg, mctg_if,
// mctg_stamp_store and mctg_tick_core.
//
//   channel  | dir | handshake        | payload
//   in_ch    | in  | valid / ready    | op, entry_index, entry_value, flags
//   out_ch   | out | valid / ready    | clock_pulse, pulse_index, blink_phase,
//            |     |                  | tick_count
//
// Sustains one item per clock while results are taken; each item passes the
// input register, loaded at acceptance, and then the state/result register,
// whose output is the offered result.
// The whole update is one pass through the tick core's compare and add chain.
// Reset (rst_n low, synchronous) clears the state and the table to zero.
// A result that is not taken halts processing; the input register then holds
// one more item and ready drops until the result leaves.

module midi_clock_tick_generator_top #(
  parameter int PULSES_PER_BEAT = 24,
  parameter int STAMP_WIDTH     = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  mctg_in_if.sink         in_ch,
  mctg_out_if.source      out_ch
);
  import mctg_pkg::*;

  localparam int ADDR_W = $clog2(PULSES_PER_BEAT + 3);

  logic                   in_valid_r;
  item_t                  in_item_r;
  logic                   out_valid_r;
  logic                   advance;
  logic                   fire;
  stamp_wr_t              wr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [STAMP_WIDTH-1:0] rd_stamp, stamp0, stamp1, stamp2;
  result_t                result;

  // Move forward whenever the result slot is free or being emptied
  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r  <= in_ch.valid;
      if (advance)     out_valid_r <= in_valid_r;
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.op            <= op_t'(in_ch.op);
      in_item_r.entry_index   <= in_ch.entry_index;
      in_item_r.entry_value   <= in_ch.entry_value;
      in_item_r.stop_request  <= in_ch.stop_request;
      in_item_r.start_request <= in_ch.start_request;
      in_item_r.playing       <= in_ch.playing;
      in_item_r.tempo_raised  <= in_ch.tempo_raised;
    end
  end

  mctg_stamp_store #(
    .PULSES_PER_BEAT (PULSES_PER_BEAT),
    .STAMP_WIDTH     (STAMP_WIDTH)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_stamp (rd_stamp),
    .stamp0   (stamp0),
    .stamp1   (stamp1),
    .stamp2   (stamp2)
  );

  mctg_tick_core #(
    .PULSES_PER_BEAT (PULSES_PER_BEAT),
    .STAMP_WIDTH     (STAMP_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (in_item_r),
    .rd_stamp (rd_stamp),
    .stamp0   (stamp0),
    .stamp1   (stamp1),
    .stamp2   (stamp2),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .result   (result)
  );

  // Drive the result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.clock_pulse = result.clock_pulse;
  assign out_ch.pulse_index = result.pulse_index;
  assign out_ch.blink_phase = result.blink_phase;
  assign out_ch.tick_count  = result.tick_count;

endmodule

### hw/rtl/mctg_stamp_store.sv
// Pulse timestamp table: flip-flop entries, one write port, one indexed read
// port and fixed taps on the first three entries. Depends on mctg_pkg.

module mctg_stamp_store #(
  parameter int  PULSES_PER_BEAT = 24,
  parameter int  STAMP_WIDTH     = 16,
  localparam int ADDR_W          = $clog2(PULSES_PER_BEAT + 3)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mctg_pkg::stamp_wr_t    wr,
  input  logic [ADDR_W-1:0]      rd_addr,
  output logic [STAMP_WIDTH-1:0] rd_stamp,
  output logic [STAMP_WIDTH-1:0] stamp0,
  output logic [STAMP_WIDTH-1:0] stamp1,
  output logic [STAMP_WIDTH-1:0] stamp2
);
  import mctg_pkg::*;

  // Entries past the write index range can never be loaded and read as zero
  localparam int DEPTH    = PULSES_PER_BEAT + 1;
  localparam int MAX_WR   = 2 ** IDX_FIELD_W;
  localparam int STORED   = (DEPTH < MAX_WR) ? DEPTH : MAX_WR;
  localparam int SA_W     = $clog2(STORED);
  localparam logic [ADDR_W-1:0] STORED_A = ADDR_W'(STORED);

  logic [STAMP_WIDTH-1:0] mem_r [STORED];
  logic                   rd_hit;

  // Load one entry per write item; the core has already range-checked it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STORED; k++) begin
        mem_r[k] <= '0;
      end
    end else if (wr.en) begin
      mem_r[wr.idx[SA_W-1:0]] <= STAMP_WIDTH'(wr.value);
    end
  end

  // Indexed read, zero beyond the table
  assign rd_hit   = (rd_addr < STORED_A);
  assign rd_stamp = rd_hit ? mem_r[rd_addr[SA_W-1:0]] : '0;

  // Fixed taps used by a beat restart and by the tempo cap
  assign stamp0 = mem_r[SA_W'(0)];
  assign stamp1 = mem_r[SA_W'(1)];
  assign stamp2 = mem_r[SA_W'(2)];

endmodule

### hw/rtl/mctg_tick_core.sv
// Tick state and its one-pass update: counter, pulse index, next stamp,
// blink phase, plus shadow copies of the three table entries the index
// looks at. Depends on mctg_pkg; reads the table through mctg_stamp_store.

module mctg_tick_core #(
  parameter int  PULSES_PER_BEAT = 24,
  parameter int  STAMP_WIDTH     = 16,
  localparam int ADDR_W          = $clog2(PULSES_PER_BEAT + 3)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  mctg_pkg::item_t        item,
  input  logic [STAMP_WIDTH-1:0] rd_stamp,
  input  logic [STAMP_WIDTH-1:0] stamp0,
  input  logic [STAMP_WIDTH-1:0] stamp1,
  input  logic [STAMP_WIDTH-1:0] stamp2,
  output mctg_pkg::stamp_wr_t    wr,
  output logic [ADDR_W-1:0]      rd_addr,
  output mctg_pkg::result_t      result
);
  import mctg_pkg::*;

  localparam int IDX_W  = $clog2(PULSES_PER_BEAT);
  localparam int CMP_W  = (ADDR_W > IDX_FIELD_W) ? ADDR_W : IDX_FIELD_W;
  localparam int DEPTH  = PULSES_PER_BEAT + 1;
  localparam int MAX_WR = 2 ** IDX_FIELD_W;
  localparam int STORED = (DEPTH < MAX_WR) ? DEPTH : MAX_WR;
  localparam logic [IDX_W-1:0] LAST_PULSE = IDX_W'(PULSES_PER_BEAT - 1);
  localparam logic [CMP_W-1:0] STORED_C   = CMP_W'(STORED);

  // State; cur/tgt/ahd mirror table entries at index, index+1, index+2
  logic [STAMP_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [STAMP_WIDTH-1:0] next_r, next_nxt;
  logic [STAMP_WIDTH-1:0] cur_r, cur_nxt;
  logic [STAMP_WIDTH-1:0] tgt_r, tgt_nxt;
  logic [STAMP_WIDTH-1:0] ahd_r, ahd_nxt;
  logic [IDX_W-1:0]       sync_r, sync_nxt;
  logic [IDX_W-1:0]       blink_r, blink_nxt;
  logic                   pulse_r, pulse_nxt;

  // View of the state after an optional stop
  logic [IDX_W-1:0]       i_eff;
  logic [STAMP_WIDTH-1:0] cnt_eff, next_eff, cur_eff, tgt_eff, ahd_eff;
  logic [STAMP_WIDTH-1:0] gap, left, adj, adj_min, cnt_t, cnt_inc;
  logic                   hit, over;
  logic [CMP_W-1:0]       wr_idx_c, i_c;
  logic                   wr_ok;
  logic [STAMP_WIDTH-1:0] wr_val;

  // On a tick item, a stop restarts the beat before normal processing
  always_comb begin
    if (item.stop_request) begin
      i_eff    = '0;
      cnt_eff  = '0;
      next_eff = stamp1;
      cur_eff  = stamp0;
      tgt_eff  = stamp1;
      ahd_eff  = stamp2;
    end else begin
      i_eff    = sync_r;
      cnt_eff  = cnt_r;
      next_eff = next_r;
      cur_eff  = cur_r;
      tgt_eff  = tgt_r;
      ahd_eff  = ahd_r;
    end
  end

  // Fetch the entry three ahead, which becomes the new look-ahead on a step
  assign rd_addr = ADDR_W'(i_eff) + ADDR_W'(3);

  // Tempo re-align: wrap-around differences, unsigned cap at entry one
  assign gap     = tgt_eff - cur_eff;
  assign left    = next_eff - cnt_eff;
  assign adj     = gap - left;
  assign adj_min = (stamp1 < adj) ? stamp1 : adj;
  assign cnt_t   = item.tempo_raised ? (cur_eff + adj_min) : cnt_eff;
  assign hit     = (cnt_t == tgt_eff);
  assign over    = (cnt_t > tgt_eff);
  assign cnt_inc = cnt_t + STAMP_WIDTH'(1);

  // Table write command, dropped beyond the last entry
  assign wr_idx_c = CMP_W'(item.entry_index);
  assign i_c      = CMP_W'(sync_r);
  assign wr_ok    = (wr_idx_c < STORED_C);
  assign wr_val   = STAMP_WIDTH'(item.entry_value);
  assign wr.en    = fire && (item.op == OP_WRITE) && wr_ok;
  assign wr.idx   = item.entry_index;
  assign wr.value = item.entry_value;

  always_comb begin
    cnt_nxt   = cnt_r;
    next_nxt  = next_r;
    cur_nxt   = cur_r;
    tgt_nxt   = tgt_r;
    ahd_nxt   = ahd_r;
    sync_nxt  = sync_r;
    blink_nxt = blink_r;
    pulse_nxt = 1'b0;
    case (item.op)
      OP_WRITE: begin
        // Keep the shadows coherent with the table
        if (wr_ok) begin
          if (wr_idx_c == i_c)                 cur_nxt = wr_val;
          if (wr_idx_c == i_c + CMP_W'(1))     tgt_nxt = wr_val;
          if (wr_idx_c == i_c + CMP_W'(2))     ahd_nxt = wr_val;
        end
      end
      OP_TICK: begin
        if (item.start_request) begin
          // Restart the beat and skip the compare
          cnt_nxt  = '0;
          sync_nxt = '0;
          next_nxt = stamp1;
          cur_nxt  = stamp0;
          tgt_nxt  = stamp1;
          ahd_nxt  = stamp2;
        end else begin
          sync_nxt = i_eff;
          next_nxt = next_eff;
          cur_nxt  = cur_eff;
          tgt_nxt  = tgt_eff;
          ahd_nxt  = ahd_eff;
          if (hit) begin
            pulse_nxt = 1'b1;
            blink_nxt = (blink_r >= LAST_PULSE) ? '0 : blink_r + IDX_W'(1);
            if (item.playing) begin
              if (i_eff >= LAST_PULSE) begin
                cnt_nxt  = '0;
                sync_nxt = '0;
                next_nxt = stamp1;
                cur_nxt  = stamp0;
                tgt_nxt  = stamp1;
                ahd_nxt  = stamp2;
              end else begin
                // Advance to the next pulse and slide the shadows
                cnt_nxt  = cnt_inc;
                sync_nxt = i_eff + IDX_W'(1);
                next_nxt = ahd_eff;
                cur_nxt  = tgt_eff;
                tgt_nxt  = ahd_eff;
                ahd_nxt  = rd_stamp;
              end
            end else begin
              cnt_nxt = '0;
            end
          end else if (over) begin
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      default: begin
        pulse_nxt = 1'b0;
      end
    endcase
  end

  // Hold state unless an item is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      next_r  <= '0;
      cur_r   <= '0;
      tgt_r   <= '0;
      ahd_r   <= '0;
      sync_r  <= '0;
      blink_r <= '0;
      pulse_r <= 1'b0;
    end else if (fire) begin
      cnt_r   <= cnt_nxt;
      next_r  <= next_nxt;
      cur_r   <= cur_nxt;
      tgt_r   <= tgt_nxt;
      ahd_r   <= ahd_nxt;
      sync_r  <= sync_nxt;
      blink_r <= blink_nxt;
      pulse_r <= pulse_nxt;
    end
  end

  // The state registers double as the result register
  assign result.clock_pulse = pulse_r;
  assign result.pulse_index = IDX_FIELD_W'(sync_r);
  assign result.blink_phase = IDX_FIELD_W'(blink_r);
  assign result.tick_count  = COUNT_FIELD_W'(cnt_r);

endmodule

### hw/rtl/mctg_checker.sv
// Port-level checks for the MIDI clock tick generator and the bind that
// attaches them to midi_clock_tick_generator_top. Depends on mctg_if.

module mctg_checker #(
  parameter int PULSES_PER_BEAT = 24
) (
  input logic        clk,
  input logic        rst_n,
  mctg_in_if.sink    in_ch,
  mctg_out_if.source out_ch
);

  // No result may show right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      $stable(out_ch.clock_pulse) && $stable(out_ch.pulse_index) &&
      $stable(out_ch.blink_phase) && $stable(out_ch.tick_count))
    else $error("result payload changed while stalled");

  // Input back-pressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without a stalled result");

  // Pulse index and blink phase stay within one beat
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (PULSES_PER_BEAT > 32) ||
      ((int'(out_ch.pulse_index) < PULSES_PER_BEAT) &&
       (int'(out_ch.blink_phase) < PULSES_PER_BEAT)))
    else $error("pulse index or blink phase out of range");

endmodule

bind midi_clock_tick_generator_top mctg_checker #(
  .PULSES_PER_BEAT (PULSES_PER_BEAT)
) u_mctg_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
